>>> hw/rtl/clsr_pkg.sv
// Shared types and constants of the clipped line span rasterizer.
// Used by the channel interfaces, the controller, the datapath and the top level.
// Depends on nothing.
package clsr_pkg;

    localparam int CFG_BITS     = 16;
    localparam int CFG_IDX_BITS = 2;
    localparam int VALUE_BITS   = 8;

    localparam logic [CFG_BITS-1:0] BUF_WIDTH_RESET  = 16'd1024;
    localparam logic [CFG_BITS-1:0] BUF_HEIGHT_RESET = 16'd1024;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_BUF_LEFT   = 2'd0,
        CFG_BUF_TOP    = 2'd1,
        CFG_BUF_WIDTH  = 2'd2,
        CFG_BUF_HEIGHT = 2'd3
    } cfg_index_t;

    typedef enum logic {
        OP_START   = 1'b0,
        OP_ADVANCE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        MODE_FLAT    = 2'd0,
        MODE_SHALLOW = 2'd1,
        MODE_STEEP   = 2'd2
    } line_mode_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_line;
        logic mul_load;
        logic div_step;
        logic finish;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic needs_div;
        logic div_last;
    } dp_status_t;

endpackage

>>> hw/rtl/clsr_cmd_if.sv
// Input channel of the rasterizer: valid/ready handshake with the command payload.
// Depends on clsr_pkg for the fill value width.
interface clsr_cmd_if #(
    parameter int COORD_BITS = 16
);
    import clsr_pkg::*;

    logic                          valid;
    logic                          ready;
    logic                          op;
    logic signed [COORD_BITS-1:0]  end_a_x;
    logic signed [COORD_BITS-1:0]  end_a_y;
    logic signed [COORD_BITS-1:0]  end_b_x;
    logic signed [COORD_BITS-1:0]  end_b_y;
    logic        [VALUE_BITS-1:0]  draw_value;

    modport source (
        output valid, op, end_a_x, end_a_y, end_b_x, end_b_y, draw_value,
        input  ready
    );

    modport sink (
        input  valid, op, end_a_x, end_a_y, end_b_x, end_b_y, draw_value,
        output ready
    );

endinterface

>>> hw/rtl/clsr_span_if.sv
// Output channel of the rasterizer: valid/ready handshake with one span per transaction.
// Depends on clsr_pkg for the fill value width.
interface clsr_span_if #(
    parameter int COORD_BITS = 16
);
    import clsr_pkg::*;

    logic                          valid;
    logic                          ready;
    logic                          span_valid;
    logic signed [COORD_BITS-1:0]  row_y;
    logic signed [COORD_BITS-1:0]  span_left;
    logic signed [COORD_BITS-1:0]  span_right;
    logic        [VALUE_BITS-1:0]  pixel_value;
    logic                          line_done;

    modport source (
        output valid, span_valid, row_y, span_left, span_right, pixel_value, line_done,
        input  ready
    );

    modport sink (
        input  valid, span_valid, row_y, span_left, span_right, pixel_value, line_done,
        output ready
    );

endinterface

>>> hw/rtl/clsr_ctrl.sv
// Controller of the rasterizer: sequences multiply, divide and finish steps per row.
// Depends on clsr_pkg for the command, status and opcode types.
module clsr_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_valid,
    input  clsr_pkg::op_t           cmd_op,
    output logic                    cmd_ready,
    input  logic                    out_ready,
    output logic                    out_valid,
    input  clsr_pkg::dp_status_t    status,
    output clsr_pkg::dp_cmd_t       ctl
);
    import clsr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   out_free;

    assign cmd_ready = (state_reg == S_IDLE);
    assign accept    = cmd_valid && cmd_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    assign ctl.load_line = accept && (cmd_op == OP_START);
    assign ctl.mul_load  = (state_reg == S_MUL);
    assign ctl.div_step  = (state_reg == S_DIV);
    assign ctl.finish    = (state_reg == S_FIN) && out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (cmd_op == OP_ADVANCE))
                begin
                    state_next = status.needs_div ? S_MUL : S_FIN;
                end
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The divider only runs for an active sloped line.
    a_div_needs_line: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> status.needs_div)
        else $error("divider running without an active sloped line");

    // An accepted advance always produces work before the next transaction.
    a_adv_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd_op == OP_ADVANCE)) |=> (state_reg != S_IDLE))
        else $error("advance accepted but controller stayed idle");

    // A finished row waits while the previous result is still unclaimed.
    a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_FIN) && !out_free) |=> ((state_reg == S_FIN) && out_valid_reg))
        else $error("result overwritten while output stalled");

    a_mul_then_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |=> (state_reg == S_DIV))
        else $error("multiply step not followed by divide");

endmodule

>>> hw/rtl/clsr_dp.sv
// Datapath of the rasterizer: buffer registers, line state, multiplier, serial divider,
// clipping logic and the output payload register. Depends on clsr_pkg.
module clsr_dp #(
    parameter int COORD_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [clsr_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [clsr_pkg::CFG_BITS-1:0]         cfg_data,
    input  logic signed [COORD_BITS-1:0]          end_a_x,
    input  logic signed [COORD_BITS-1:0]          end_a_y,
    input  logic signed [COORD_BITS-1:0]          end_b_x,
    input  logic signed [COORD_BITS-1:0]          end_b_y,
    input  logic [clsr_pkg::VALUE_BITS-1:0]       draw_value,
    input  clsr_pkg::dp_cmd_t                     ctl,
    output clsr_pkg::dp_status_t                  status,
    output logic                                  span_valid,
    output logic signed [COORD_BITS-1:0]          row_y,
    output logic signed [COORD_BITS-1:0]          span_left,
    output logic signed [COORD_BITS-1:0]          span_right,
    output logic [clsr_pkg::VALUE_BITS-1:0]       pixel_value,
    output logic                                  line_done
);
    import clsr_pkg::*;

    localparam int W        = COORD_BITS;
    localparam int DN       = 2 * W + 1;
    localparam int CNT_BITS = $clog2(DN);
    localparam int QW       = W + 2;
    localparam int XW       = ((W > CFG_BITS) ? W : CFG_BITS) + 4;
    localparam logic [CNT_BITS-1:0] DIV_LAST = CNT_BITS'(DN - 1);

    // Buffer rectangle registers.
    logic signed [CFG_BITS-1:0] buf_left_reg;
    logic signed [CFG_BITS-1:0] buf_top_reg;
    logic        [CFG_BITS-1:0] buf_width_reg;
    logic        [CFG_BITS-1:0] buf_height_reg;

    // Line state.
    logic                   line_active_reg;
    line_mode_t             line_mode_reg;
    logic signed [W-1:0]    current_row_reg;
    logic signed [W-1:0]    final_row_reg;
    logic signed [W-1:0]    origin_x_reg;
    logic signed [W-1:0]    origin_y_reg;
    logic        [W-1:0]    dx_mag_reg;
    logic                   dx_neg_reg;
    logic        [W-1:0]    dy_reg;
    logic signed [W-1:0]    x_low_reg;
    logic signed [W-1:0]    x_high_reg;
    logic [VALUE_BITS-1:0]  stored_value_reg;
    logic signed [QW-1:0]   prev_quot_reg;

    // Divider.
    logic [DN-1:0]          dvd_reg;
    logic [W-1:0]           rem_reg;
    logic [CNT_BITS-1:0]    cnt_reg;

    // Output payload.
    logic                   span_valid_reg;
    logic signed [W-1:0]    row_y_reg;
    logic signed [W-1:0]    span_left_reg;
    logic signed [W-1:0]    span_right_reg;
    logic [VALUE_BITS-1:0]  pixel_value_reg;
    logic                   line_done_reg;

    // Line setup.
    logic signed [W:0]      dx_w;
    logic signed [W:0]      dy_w;
    logic signed [W:0]      dx_o;
    logic        [W:0]      adx_full;
    logic        [W:0]      ady_full;
    logic                   a_lower;
    logic                   zero_len;
    line_mode_t             mode_new;

    // Multiply and divide.
    logic [W-1:0]           row_off;
    logic [W:0]             mul_a;
    logic [DN-1:0]          product;
    logic [W:0]             trial;
    logic [W:0]             diff;
    logic                   ge;
    logic [W:0]             q_mag;
    logic signed [QW-1:0]   quot_now;

    // Clipping.
    logic signed [XW-1:0]   left_x;
    logic signed [XW-1:0]   right_x;
    logic signed [XW-1:0]   top_x;
    logic signed [XW-1:0]   bottom_x;
    logic signed [XW-1:0]   y_x;
    logic signed [XW-1:0]   p_x;
    logic signed [XW-1:0]   q_x;
    logic signed [XW-1:0]   xlo_x;
    logic signed [XW-1:0]   xhi_x;
    logic signed [XW-1:0]   xs;
    logic signed [XW-1:0]   xe;
    logic                   hit;
    logic                   span_ok;
    logic                   last_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_left_reg   <= '0;
            buf_top_reg    <= '0;
            buf_width_reg  <= BUF_WIDTH_RESET;
            buf_height_reg <= BUF_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_BUF_LEFT:   buf_left_reg   <= cfg_data;
                CFG_BUF_TOP:    buf_top_reg    <= cfg_data;
                CFG_BUF_WIDTH:  buf_width_reg  <= cfg_data;
                CFG_BUF_HEIGHT: buf_height_reg <= cfg_data;
                default:        buf_left_reg   <= buf_left_reg;
            endcase
        end
    end

    // Line setup from the two endpoints; the origin is the endpoint with the smaller row.
    always_comb
    begin
        dx_w     = (W+1)'(end_b_x) - (W+1)'(end_a_x);
        dy_w     = (W+1)'(end_b_y) - (W+1)'(end_a_y);
        adx_full = dx_w[W] ? (~dx_w + 1'b1) : dx_w;
        ady_full = dy_w[W] ? (~dy_w + 1'b1) : dy_w;
        a_lower  = (end_a_y <= end_b_y);
        dx_o     = a_lower ? dx_w : -dx_w;
        zero_len = (end_a_x == end_b_x) && (end_a_y == end_b_y);
        if (adx_full > ady_full)
        begin
            mode_new = (ady_full == '0) ? MODE_FLAT : MODE_SHALLOW;
        end
        else
        begin
            mode_new = MODE_STEEP;
        end
    end

    // A shallow line divides the offset of the next row; the current row's
    // position is the previous row's quotient, and zero on the first row.
    assign row_off = current_row_reg - origin_y_reg;
    assign mul_a   = (line_mode_reg == MODE_SHALLOW) ? ((W+1)'(row_off) + (W+1)'(1))
                                                     : (W+1)'(row_off);
    assign product = DN'(mul_a) * DN'(dx_mag_reg);

    // Restoring division step: one quotient bit per cycle.
    assign trial = {rem_reg, dvd_reg[DN-1]};
    assign diff  = trial - {1'b0, dy_reg};
    assign ge    = (trial >= {1'b0, dy_reg});

    assign q_mag    = dvd_reg[W:0];
    assign quot_now = dx_neg_reg ? -QW'(q_mag) : QW'(q_mag);

    assign status.needs_div = line_active_reg && (line_mode_reg != MODE_FLAT);
    assign status.div_last  = (cnt_reg == DIV_LAST);

    always_comb
    begin
        left_x   = XW'(buf_left_reg);
        top_x    = XW'(buf_top_reg);
        right_x  = left_x + XW'(buf_width_reg) - XW'(1);
        bottom_x = top_x + XW'(buf_height_reg) - XW'(1);
        y_x      = XW'(current_row_reg);
        p_x      = XW'(origin_x_reg) + XW'(prev_quot_reg);
        q_x      = XW'(origin_x_reg) + XW'(quot_now);
        xlo_x    = XW'(x_low_reg);
        xhi_x    = XW'(x_high_reg);
        xs       = xlo_x;
        xe       = xhi_x;
        hit      = 1'b1;
        unique case (line_mode_reg)
            MODE_FLAT:
            begin
                hit = !((xs > right_x) || (xe < left_x));
                if (xs < left_x)
                begin
                    xs = left_x;
                end
                if (xe > right_x)
                begin
                    xe = right_x;
                end
            end
            MODE_SHALLOW:
            begin
                xs  = (p_x <= q_x) ? p_x : q_x;
                xe  = ((p_x > q_x) ? p_x : q_x) - XW'(1);
                hit = !((xs > right_x) || (xe < left_x));
                if (xs < left_x)
                begin
                    xs = left_x;
                end
                if (xs < xlo_x)
                begin
                    xs = xlo_x;
                end
                if (xe > right_x)
                begin
                    xe = right_x;
                end
                if (xe > xhi_x)
                begin
                    xe = xhi_x;
                end
            end
            default:
            begin
                xs  = q_x;
                xe  = q_x;
                hit = !((q_x < left_x) || (q_x > right_x));
            end
        endcase
        span_ok  = (y_x >= top_x) && (y_x <= bottom_x) && hit && (xs <= xe);
        last_row = (line_mode_reg == MODE_FLAT) || (current_row_reg >= final_row_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_active_reg <= 1'b0;
        end
        else if (ctl.load_line)
        begin
            line_active_reg <= !zero_len;
        end
        else if (ctl.finish && line_active_reg && last_row)
        begin
            line_active_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_line)
        begin
            stored_value_reg <= draw_value;
            x_low_reg        <= (end_a_x <= end_b_x) ? end_a_x : end_b_x;
            x_high_reg       <= (end_a_x > end_b_x) ? end_a_x : end_b_x;
            origin_x_reg     <= a_lower ? end_a_x : end_b_x;
            origin_y_reg     <= a_lower ? end_a_y : end_b_y;
            current_row_reg  <= a_lower ? end_a_y : end_b_y;
            final_row_reg    <= a_lower ? end_b_y : end_a_y;
            dx_mag_reg       <= adx_full[W-1:0];
            dx_neg_reg       <= dx_o[W];
            dy_reg           <= ady_full[W-1:0];
            line_mode_reg    <= mode_new;
            prev_quot_reg    <= '0;
        end
        else if (ctl.finish && line_active_reg && !last_row)
        begin
            current_row_reg <= current_row_reg + W'(1);
            prev_quot_reg   <= quot_now;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul_load)
        begin
            dvd_reg <= product;
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (ctl.div_step)
        begin
            dvd_reg <= {dvd_reg[DN-2:0], ge};
            rem_reg <= ge ? diff[W-1:0] : trial[W-1:0];
            cnt_reg <= cnt_reg + CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.finish)
        begin
            span_valid_reg  <= line_active_reg && span_ok;
            row_y_reg       <= line_active_reg ? current_row_reg : '0;
            span_left_reg   <= (line_active_reg && span_ok) ? xs[W-1:0] : '0;
            span_right_reg  <= (line_active_reg && span_ok) ? xe[W-1:0] : '0;
            pixel_value_reg <= (line_active_reg && span_ok) ? stored_value_reg : '0;
            line_done_reg   <= !line_active_reg || last_row;
        end
    end

    assign span_valid  = span_valid_reg;
    assign row_y       = row_y_reg;
    assign span_left   = span_left_reg;
    assign span_right  = span_right_reg;
    assign pixel_value = pixel_value_reg;
    assign line_done   = line_done_reg;

endmodule

>>> hw/rtl/clipped_line_span_rasterizer_top.sv
// Top level of the clipped line span rasterizer: controller plus datapath.
// Depends on clsr_pkg, clsr_cmd_if, clsr_span_if, clsr_ctrl and clsr_dp.
//
// Usage. Commands arrive as transactions on the cmd channel. A start transaction
// (op 0) loads a line's two endpoints and its fill byte and produces no result.
// Each advance transaction (op 1) handles one row of the line, from the lower
// row to the higher, and produces exactly one transaction on the span channel,
// clipped to the buffer rectangle set through the cfg write port.
// A sloped line row runs a multiply step, a restoring divide (one quotient bit
// per cycle) and a finish step; a flat line, or an advance with no active line,
// goes straight to the finish step. A new command is accepted only once the
// controller is back in idle.
// The result sits in an output register; while it waits to be taken the block
// still accepts and works on the next transaction, and only a finished row that
// finds the register still occupied waits in its finish step.
// Reset clears the active-line flag and the output valid, and sets the buffer to
// origin 0,0 with width and height 1024. The user must write configuration only
// while idle; the block itself does not enforce it.
module clipped_line_span_rasterizer_top #(
    parameter int COORD_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    clsr_cmd_if.sink                              cmd,
    clsr_span_if.source                           span,
    input  logic                                  cfg_we,
    input  logic [clsr_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [clsr_pkg::CFG_BITS-1:0]         cfg_data
);
    import clsr_pkg::*;

    // Command and status bundles between the controller and the datapath.
    dp_cmd_t    ctl;
    dp_status_t status;

    // The controller owns both handshakes; the datapath owns every payload.
    clsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_op    (op_t'(cmd.op)),
        .cmd_ready (cmd.ready),
        .out_ready (span.ready),
        .out_valid (span.valid),
        .status    (status),
        .ctl       (ctl)
    );

    clsr_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .end_a_x     (cmd.end_a_x),
        .end_a_y     (cmd.end_a_y),
        .end_b_x     (cmd.end_b_x),
        .end_b_y     (cmd.end_b_y),
        .draw_value  (cmd.draw_value),
        .ctl         (ctl),
        .status      (status),
        .span_valid  (span.span_valid),
        .row_y       (span.row_y),
        .span_left   (span.span_left),
        .span_right  (span.span_right),
        .pixel_value (span.pixel_value),
        .line_done   (span.line_done)
    );

endmodule
